FILE: design/i2cbw_pkg.sv
// Shared types and constants for the I2C bit-bang byte writer.
package i2cbw_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic SEL_CLOCK = 1'b0;
  localparam logic SEL_DATA  = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             send_start;
    logic             send_stop;
  } cmd_t;

endpackage

FILE: design/i2cbw_front.sv
// Front end: input request register that hands byte commands to the command queue.
module i2cbw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [7:0]              in_byte_value,
  input  logic                    in_send_start,
  input  logic                    in_send_stop,
  output logic                    q_push,
  input  logic                    q_full,
  output i2cbw_pkg::cmd_t         q_cmd
);
  import i2cbw_pkg::*;

  logic in_valid_r;
  logic in_valid_nxt;
  cmd_t cmd_r;
  logic accept;

  assign in_full = in_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = in_valid_r && !q_full;
  assign q_cmd   = cmd_r;

  assign in_valid_nxt = accept || (in_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.byte_value <= in_byte_value;
      cmd_r.send_start <= in_send_start;
      cmd_r.send_stop  <= in_send_stop;
    end
  end

endmodule

FILE: design/i2cbw_cmd_q.sv
// Small flop-based command queue between the front end and the sequencer.
module i2cbw_cmd_q #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cbw_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output i2cbw_pkg::cmd_t pop_cmd
);
  import i2cbw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == FullCnt);
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/i2cbw_back.sv
// Back end: pin update sequencer with its output register.
module i2cbw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2cbw_pkg::cmd_t q_cmd,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic            out_pin_select,
  output logic            out_pin_level,
  output logic            out_last_step
);
  import i2cbw_pkg::*;

  typedef enum logic [1:0] {
    S_START,
    S_DATA,
    S_ACK,
    S_STOP
  } phase_t;

  phase_t     state_r, state_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       stop_r, stop_nxt;

  logic out_valid_r, out_valid_nxt;
  logic sel_r, sel_nxt;
  logic lvl_r, lvl_nxt;
  logic last_r, last_nxt;

  logic out_ready;
  logic adv;
  logic step_sel, step_lvl, step_last;
  logic load;

  assign out_ready = !out_valid_r || out_pop;
  assign adv       = busy_r && out_ready;
  assign out_empty = !out_valid_r;
  assign out_pin_select = sel_r;
  assign out_pin_level  = lvl_r;
  assign out_last_step  = last_r;

  always_comb begin
    step_sel  = SEL_CLOCK;
    step_lvl  = 1'b0;
    step_last = 1'b0;
    unique case (state_r)
      S_START: begin
        step_sel = sub_r[0] ? SEL_CLOCK : SEL_DATA;
        step_lvl = !sub_r[1];
      end
      S_DATA: begin
        step_sel = (sub_r == 2'd0) ? SEL_DATA : SEL_CLOCK;
        step_lvl = (sub_r == 2'd0) ? shift_r[7] : (sub_r == 2'd1);
      end
      S_ACK: begin
        step_sel  = (sub_r == 2'd0) ? SEL_DATA : SEL_CLOCK;
        step_lvl  = (sub_r != 2'd2);
        step_last = (sub_r == 2'd2) && !stop_r;
      end
      S_STOP: begin
        step_sel  = (sub_r == 2'd1) ? SEL_CLOCK : SEL_DATA;
        step_lvl  = (sub_r != 2'd0);
        step_last = (sub_r == 2'd2);
      end
      default: begin
        step_sel = SEL_CLOCK;
      end
    endcase
  end

  assign load  = q_valid && (!busy_r || (adv && step_last));
  assign q_pop = load;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    sub_nxt   = sub_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    stop_nxt  = stop_r;
    if (adv) begin
      sub_nxt = sub_r + 2'd1;
      unique case (state_r)
        S_START: begin
          if (sub_r == 2'd3) begin
            state_nxt = S_DATA;
            sub_nxt   = 2'd0;
          end
        end
        S_DATA: begin
          if (sub_r == 2'd2) begin
            sub_nxt   = 2'd0;
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 3'd1;
            if (bit_r == 3'd7) begin
              state_nxt = S_ACK;
            end
          end
        end
        S_ACK: begin
          if (sub_r == 2'd2) begin
            sub_nxt   = 2'd0;
            state_nxt = S_STOP;
          end
        end
        S_STOP: begin
          if (sub_r == 2'd2) begin
            sub_nxt = 2'd0;
          end
        end
        default: begin
          sub_nxt = 2'd0;
        end
      endcase
      if (step_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      state_nxt = q_cmd.send_start ? S_START : S_DATA;
      sub_nxt   = 2'd0;
      bit_nxt   = 3'd0;
      shift_nxt = q_cmd.byte_value;
      stop_nxt  = q_cmd.send_stop;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    lvl_nxt       = lvl_r;
    last_nxt      = last_r;
    if (out_ready) begin
      out_valid_nxt = adv;
      sel_nxt       = step_sel;
      lvl_nxt       = step_lvl;
      last_nxt      = step_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_START;
      busy_r      <= 1'b0;
      sub_r       <= 2'd0;
      bit_r       <= 3'd0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    sel_r   <= sel_nxt;
    lvl_r   <= lvl_nxt;
    last_r  <= last_nxt;
  end

`ifndef SYNTHESIS
  a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r || (adv && step_last)))
    else $error("command taken in the middle of a byte");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && state_r != S_START) |-> (sub_r != 2'd3))
    else $error("step counter out of range");

  a_last_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_last) |=> (!busy_r || (sub_r == 2'd0 && bit_r == 3'd0 &&
      (state_r == S_START || state_r == S_DATA))))
    else $error("sequencer did not restart after final pin update");

  a_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_last) |-> (state_r == S_ACK || state_r == S_STOP))
    else $error("final pin update outside acknowledge or stop");
`endif

endmodule

FILE: design/i2c_bitbang_byte_writer.sv
// Top level of the I2C bit-bang byte writer: front end, command queue, sequencer.
// A request's first pin update reaches the result ports through the input register, the
// command queue, the sequencer state and the sequencer output register when the block is idle.
// Throughput: one pin update per cycle from the sequencer unless the full output register
// waits for out_pop; the next byte follows with no gap.
// Reset (synchronous, active low) empties the input register, queue and output register.
module i2c_bitbang_byte_writer #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte_value,
  input  logic       in_send_start,
  input  logic       in_send_stop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_pin_select,
  output logic       out_pin_level,
  output logic       out_last_step
);
  import i2cbw_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_push, q_full, q_pop, q_valid;

  i2cbw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_byte_value (in_byte_value),
    .in_send_start (in_send_start),
    .in_send_stop  (in_send_stop),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_cmd         (front_cmd)
  );

  i2cbw_cmd_q #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (back_cmd)
  );

  i2cbw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (back_cmd),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pin_select (out_pin_select),
    .out_pin_level  (out_pin_level),
    .out_last_step  (out_last_step)
  );

endmodule
